// ----- hdl/sxfs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sparse XOR file scrambler package
// Shared constants, codes, types and the table CRC function.
// ----------------------------------------------------------------------------
package sxfs_pkg;

   localparam int KEY_MAX_DEF    = 64;
   localparam int HEAD_BYTES_DEF = 1024;
   localparam int TABLE_WORDS    = 256;
   localparam int TBL_AW         = $clog2(TABLE_WORDS);
   localparam int CSR_IDX_W      = 1;

   localparam logic [31:0] CRC_POLY = 32'h8320DDB8;
   localparam logic [16:0] MIN_STEP = 17'd4;
   localparam logic [16:0] STEP_RST = 17'd64;

   typedef enum logic [1:0] {
      ACT_RESTART = 2'd0,
      ACT_KEY     = 2'd1,
      ACT_DATA    = 2'd2,
      ACT_NONE    = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      STS_OK       = 2'd0,
      STS_NO_KEY   = 2'd1,
      STS_KEY_FULL = 2'd2
   } status_type;

   localparam logic [CSR_IDX_W-1:0] CSR_FILE_SIZE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP      = 1'b1;

   // One table write, as issued by the builder.
   typedef struct packed {
      logic              en;
      logic [TBL_AW-1:0] addr;
      logic [31:0]       data;
   } tbl_wr_type;

   // Reflected CRC of one index byte, eight shift steps.
   function automatic logic [31:0] crc_byte(input logic [TBL_AW-1:0] idx);
      logic [31:0] c;
      c = 32'(idx);
      for (int b = 0; b < 8; b++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// ----- hdl/sxfs_key_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key store
// Synchronous key byte memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module sxfs_key_store #(
   parameter int KEY_MAX = sxfs_pkg::KEY_MAX_DEF,
   parameter int KIW     = 6
) (
   input  logic           clock,
   input  logic           wr_en,
   input  logic [KIW-1:0] wr_addr,
   input  logic [7:0]     wr_data,
   input  logic [KIW-1:0] rd_addr,
   output logic [7:0]     rd_data
);
   import sxfs_pkg::*;

   logic [7:0] mem [KEY_MAX];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/sxfs_table_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyed table store
// Synchronous 256-word memory with one write port and one registered read.
// ----------------------------------------------------------------------------
module sxfs_table_store (
   input  logic                        clock,
   input  sxfs_pkg::tbl_wr_type        wr,
   input  logic [sxfs_pkg::TBL_AW-1:0] rd_addr,
   output logic [31:0]                 rd_data
);
   import sxfs_pkg::*;

   logic [31:0] mem [TABLE_WORDS];
   logic [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/sxfs_table_build.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyed table builder
// Sweeps all table words: reads the key byte, adds CRC and file size, writes.
// ----------------------------------------------------------------------------
module sxfs_table_build #(
   parameter int KIW = 6,
   parameter int KCW = 7
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [KCW-1:0]       key_count,
   input  logic [31:0]          file_size,
   output logic [KIW-1:0]       key_rd_addr,
   input  logic [7:0]           key_rd_data,
   output sxfs_pkg::tbl_wr_type tbl_wr,
   output logic                 done
);
   import sxfs_pkg::*;

   logic              busy_ff, busy_in;
   logic [TBL_AW:0]   cnt_ff, cnt_in;
   logic [KIW-1:0]    kidx_ff, kidx_in;
   logic              pend_ff, pend_in;
   logic [TBL_AW-1:0] waddr_ff;
   logic [31:0]       crc_ff;
   logic              issue_rd;
   logic [KCW:0]      kidx_inc;
   logic              kidx_wrap;

   assign issue_rd  = busy_ff & ~cnt_ff[TBL_AW];
   assign kidx_inc  = (KCW+1)'(kidx_ff) + (KCW+1)'(1);
   assign kidx_wrap = kidx_inc >= (KCW+1)'(key_count);

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      kidx_in = kidx_ff;
      pend_in = issue_rd;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         kidx_in = '0;
      end else if (issue_rd) begin
         cnt_in  = cnt_ff + (TBL_AW+1)'(1);
         kidx_in = kidx_wrap ? '0 : kidx_inc[KIW-1:0];
      end else begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pend_ff <= 1'b0;
         cnt_ff  <= '0;
         kidx_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         pend_ff <= pend_in;
         cnt_ff  <= cnt_in;
         kidx_ff <= kidx_in;
      end
   end

   always_ff @(posedge clock) begin
      waddr_ff <= cnt_ff[TBL_AW-1:0];
      crc_ff   <= crc_byte(cnt_ff[TBL_AW-1:0]);
   end

   assign key_rd_addr = kidx_ff;
   assign tbl_wr.en   = pend_ff;
   assign tbl_wr.addr = waddr_ff;
   assign tbl_wr.data = crc_ff + file_size + {{24{key_rd_data[7]}}, key_rd_data};
   assign done        = busy_ff & cnt_ff[TBL_AW];

endmodule

// ----- hdl/sparse_xor_file_scrambler.sv -----
`timescale 1ns / 1ps
// Timing: restart, key and error transactions answer in the cycle after accept;
// a data byte answers once its table read is done and it has passed the data
// state, and when it first triggers the 256-word table build it waits in the
// build state and issues its table read from the lookup state.
// Throughput: one non-data transaction per cycle unless the response stalls; a
// data byte is taken only once the last has left the data state (registered table read).
// Reset (synchronous, active high) clears the control state and CSR registers.
// ----------------------------------------------------------------------------
// Sparse XOR file scrambler top level
// Keyed table XOR scrambler: key store, table builder, table memory and the
// sequencer that walks the file head and the sparse block region.
// ----------------------------------------------------------------------------
module sparse_xor_file_scrambler #(
   parameter int KEY_MAX    = sxfs_pkg::KEY_MAX_DEF,
   parameter int HEAD_BYTES = sxfs_pkg::HEAD_BYTES_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [1:0]                     req_action,
   input  logic [7:0]                     req_value_byte,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [7:0]                     rsp_out_byte,
   output logic [1:0]                     rsp_status,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [sxfs_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                    csr_data
);
   import sxfs_pkg::*;

   localparam int KIW = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
   localparam int KCW = $clog2(KEY_MAX + 1);

   // Sequencer states. A data byte either issues its table read straight
   // from idle, or waits in the build state and issues it from lookup.
   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_BUILD  = 4'b0010,
      S_LOOKUP = 4'b0100,
      S_DATA   = 4'b1000
   } state_type;

   state_type         state_ff, state_in;
   logic [KCW-1:0]    key_count_ff, key_count_in;
   logic              table_ready_ff, table_ready_in;
   logic [31:0]       pos_ff, pos_in;
   logic [16:0]       offset_ff, offset_in;
   logic [7:0]        blk_idx_ff, blk_idx_in;
   logic [31:0]       file_size_ff;
   logic [16:0]       step_ff;

   // Payload captured at accept and at the table read.
   logic [7:0]        val_ff;
   logic              head_hit_ff, tail_ff, off_lt4_ff;
   logic [1:0]        lane_ff;
   logic [31:0]       start_ff;
   logic [16:0]       step_eff_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_byte_ff;
   logic [1:0]        rsp_status_ff;

   logic              req_acc, out_free;
   action_type        act;
   logic              key_empty, key_full, acc_data_ok;
   logic              issue, build_start, build_done;
   logic              pos_lt_size, pos_lt_head, head_hit, tail;
   logic [16:0]       step_eff;
   logic [17:0]       off_inc;
   logic              blk_end;
   logic [TBL_AW-1:0] tbl_rd_addr;
   logic [31:0]       tbl_rd_data;
   tbl_wr_type        tbl_wr;
   logic              key_wr_en;
   logic [KIW-1:0]    key_rd_addr;
   logic [7:0]        key_rd_data;
   logic [7:0]        sel_byte;
   logic [31:0]       size_room;
   logic              xor_en;
   logic              rsp_wr;
   logic [7:0]        rsp_byte_nxt;
   status_type        rsp_status_nxt;

   // ------------------------------------------------------------------------
   // Handshakes. A new transaction is taken in idle whenever the response
   // register is empty or is being emptied in the same cycle, so a result that
   // is being taken never blocks the next request.
   // ------------------------------------------------------------------------
   assign out_free  = ~rsp_valid_ff | ~rsp_stall;
   assign req_stall = ~((state_ff == S_IDLE) & out_free);
   assign req_acc   = req_valid & ~req_stall;
   assign act       = action_type'(req_action);
   assign csr_ready = 1'b1;

   assign key_empty   = (key_count_ff == '0);
   assign key_full    = (key_count_ff >= KCW'(KEY_MAX));
   assign acc_data_ok = req_acc & (act == ACT_DATA) & ~key_empty;
   assign build_start = acc_data_ok & ~table_ready_ff;
   assign issue       = (acc_data_ok & table_ready_ff) | (state_ff == S_LOOKUP);
   assign key_wr_en   = req_acc & (act == ACT_KEY) & ~key_full;

   // ------------------------------------------------------------------------
   // Position decode. The head covers the first min(file size, HEAD_BYTES)
   // bytes; past it and below the file size lies the sparse block region.
   // ------------------------------------------------------------------------
   assign pos_lt_size = pos_ff < file_size_ff;
   assign pos_lt_head = pos_ff < 32'(HEAD_BYTES);
   assign head_hit    = pos_lt_size & pos_lt_head;
   assign tail        = pos_lt_size & ~pos_lt_head;
   assign step_eff    = (step_ff < MIN_STEP) ? MIN_STEP : step_ff;
   assign off_inc     = {1'b0, offset_ff} + 18'd1;
   assign blk_end     = off_inc >= {1'b0, step_eff};
   assign tbl_rd_addr = head_hit ? pos_ff[TBL_AW+1:2] : blk_idx_ff;

   // ------------------------------------------------------------------------
   // Result of a data byte, formed in the cycle after the table read. The
   // full-block test compares the bytes left from the block start with the
   // step, so a trailing partial block passes unchanged.
   // ------------------------------------------------------------------------
   always_comb begin
      case (lane_ff)
         2'd0:    sel_byte = tbl_rd_data[7:0];
         2'd1:    sel_byte = tbl_rd_data[15:8];
         2'd2:    sel_byte = tbl_rd_data[23:16];
         default: sel_byte = tbl_rd_data[31:24];
      endcase
   end

   assign size_room = file_size_ff - start_ff;
   assign xor_en    = head_hit_ff
                    | (tail_ff & off_lt4_ff & (size_room >= {15'b0, step_eff_ff}));

   // ------------------------------------------------------------------------
   // Sequencer and position counters.
   // ------------------------------------------------------------------------
   always_comb begin
      state_in       = state_ff;
      key_count_in   = key_count_ff;
      table_ready_in = table_ready_ff;
      pos_in         = pos_ff;
      offset_in      = offset_ff;
      blk_idx_in     = blk_idx_ff;
      rsp_wr         = 1'b0;
      rsp_byte_nxt   = 8'd0;
      rsp_status_nxt = STS_OK;

      unique case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               unique case (act)
                  ACT_RESTART: begin
                     key_count_in   = '0;
                     table_ready_in = 1'b0;
                     pos_in         = '0;
                     offset_in      = '0;
                     blk_idx_in     = '0;
                     rsp_wr         = 1'b1;
                  end
                  ACT_KEY: begin
                     rsp_wr = 1'b1;
                     if (key_full) begin
                        rsp_status_nxt = STS_KEY_FULL;
                     end else begin
                        key_count_in = key_count_ff + KCW'(1);
                     end
                  end
                  ACT_DATA: begin
                     if (key_empty) begin
                        rsp_wr         = 1'b1;
                        rsp_status_nxt = STS_NO_KEY;
                     end else if (table_ready_ff) begin
                        state_in = S_DATA;
                     end else begin
                        state_in = S_BUILD;
                     end
                  end
                  default: begin
                     rsp_wr = 1'b1;
                  end
               endcase
            end
         end
         S_BUILD: begin
            if (build_done) begin
               table_ready_in = 1'b1;
               state_in       = S_LOOKUP;
            end
         end
         S_LOOKUP: begin
            state_in = S_DATA;
         end
         S_DATA: begin
            rsp_wr       = 1'b1;
            rsp_byte_nxt = val_ff ^ (xor_en ? sel_byte : 8'd0);
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // The counters move when the table read for a data byte goes out.
      if (issue) begin
         if (tail) begin
            if (blk_end) begin
               offset_in  = '0;
               blk_idx_in = blk_idx_ff + 8'd1;
            end else begin
               offset_in = off_inc[16:0];
            end
         end
         if (pos_ff != 32'hFFFF_FFFF) begin
            pos_in = pos_ff + 32'd1;
         end
      end

      rsp_valid_in = rsp_wr | (rsp_valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         key_count_ff   <= '0;
         table_ready_ff <= 1'b0;
         pos_ff         <= '0;
         offset_ff      <= '0;
         blk_idx_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
         file_size_ff   <= '0;
         step_ff        <= STEP_RST;
      end else begin
         state_ff       <= state_in;
         key_count_ff   <= key_count_in;
         table_ready_ff <= table_ready_in;
         pos_ff         <= pos_in;
         offset_ff      <= offset_in;
         blk_idx_ff     <= blk_idx_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (csr_valid & csr_ready) begin
            if (csr_index == CSR_FILE_SIZE) begin
               file_size_ff <= csr_data;
            end else if (csr_index == CSR_STEP) begin
               step_ff <= csr_data[16:0];
            end
         end
      end
   end

   // Payload registers, loaded on their enables only.
   always_ff @(posedge clock) begin
      if (req_acc) begin
         val_ff <= req_value_byte;
      end
      if (issue) begin
         head_hit_ff <= head_hit;
         tail_ff     <= tail;
         off_lt4_ff  <= offset_ff < 17'd4;
         lane_ff     <= head_hit ? pos_ff[1:0] : offset_ff[1:0];
         start_ff    <= pos_ff - {15'b0, offset_ff};
         step_eff_ff <= step_eff;
      end
      if (rsp_wr) begin
         rsp_byte_ff   <= rsp_byte_nxt;
         rsp_status_ff <= rsp_status_nxt;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_status   = rsp_status_ff;

   // ------------------------------------------------------------------------
   // Storage and the table build sweep.
   // ------------------------------------------------------------------------
   sxfs_key_store #(
      .KEY_MAX (KEY_MAX),
      .KIW     (KIW)
   ) u_key_store (
      .clock   (clock),
      .wr_en   (key_wr_en),
      .wr_addr (key_count_ff[KIW-1:0]),
      .wr_data (req_value_byte),
      .rd_addr (key_rd_addr),
      .rd_data (key_rd_data)
   );

   sxfs_table_build #(
      .KIW (KIW),
      .KCW (KCW)
   ) u_table_build (
      .clock       (clock),
      .reset       (reset),
      .start       (build_start),
      .key_count   (key_count_ff),
      .file_size   (file_size_ff),
      .key_rd_addr (key_rd_addr),
      .key_rd_data (key_rd_data),
      .tbl_wr      (tbl_wr),
      .done        (build_done)
   );

   sxfs_table_store u_table_store (
      .clock   (clock),
      .wr      (tbl_wr),
      .rd_addr (tbl_rd_addr),
      .rd_data (tbl_rd_data)
   );

   // ------------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------------
`ifndef SYNTHESIS
   // Every accepted transaction either has its response loaded or is still
   // being worked on in the next cycle.
   a_acc_progress: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> (rsp_valid_ff || (state_ff != S_IDLE)))
      else $error("accepted transaction neither answered nor in progress");

   // The response register is empty whenever a data result is formed.
   a_data_slot_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DATA) |-> !rsp_valid_ff)
      else $error("data result would overwrite a pending response");

   // The key count never passes the store depth.
   a_key_count_max: assert property (@(posedge clock) disable iff (reset)
      key_count_ff <= KCW'(KEY_MAX))
      else $error("key count beyond key store depth");

   // The table is never marked ready while it is being built.
   a_build_not_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_BUILD) |-> !table_ready_ff)
      else $error("table marked ready during build");
`endif

endmodule
